>>> hdl/lsc_pkg.sv
// Shared constants, types and tables of the Lanczos coefficient generator.
`default_nettype none
package lsc_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int COEF_BITS    = 16;
  localparam int ADDR_W       = 3;

  localparam int MOD_STEPS    = 23;
  localparam int ANG_STEPS    = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int SINC_STEPS   = 31;
  // fix, select, multiply, add and final stages on top of the iterative ones
  localparam int LANE_LAT     = MOD_STEPS + ANG_STEPS + CORDIC_STEPS + SINC_STEPS + 5;

  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic [30:0]        ONE_MAG      = 31'd1073741824;
  localparam logic [17:0]        PI_Q16       = 18'd205887;

  localparam int ROUND_SH = 61 - COEF_BITS;
  localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef enum logic {
    REG_WINDOW_LOBES,
    REG_PHASE_COUNT
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  window_lobes;
    logic [17:0] phase_count;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [22:0] idx;
    logic [23:0] apos;
    logic        pneg;
    logic [22:0] d1;
    logic [22:0] d2;
  } front_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [22:0] idx;
  } side_t;

  function automatic logic signed [31:0] atan_turn(input int i);
    case (i)
      0:  return 32'sd536870912;
      1:  return 32'sd316933406;
      2:  return 32'sd167458907;
      3:  return 32'sd85004756;
      4:  return 32'sd42667331;
      5:  return 32'sd21354465;
      6:  return 32'sd10679838;
      7:  return 32'sd5340245;
      8:  return 32'sd2670163;
      9:  return 32'sd1335087;
      10: return 32'sd667544;
      11: return 32'sd333772;
      12: return 32'sd166886;
      13: return 32'sd83443;
      14: return 32'sd41722;
      15: return 32'sd20861;
      16: return 32'sd10430;
      17: return 32'sd5215;
      18: return 32'sd2608;
      19: return 32'sd1304;
      20: return 32'sd652;
      21: return 32'sd326;
      22: return 32'sd163;
      23: return 32'sd81;
      default: return 32'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> hdl/lsc_if.sv
// Request and result channel interfaces.
`default_nettype none
interface lsc_in_if;
  logic        valid;
  logic        ready;
  logic [17:0] phase_offset;
  logic [4:0]  tap_number;
  modport source (output valid, output phase_offset, output tap_number, input ready);
  modport sink (input valid, input phase_offset, input tap_number, output ready);
endinterface

interface lsc_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [lsc_pkg::COEF_BITS-1:0] coefficient;
  logic [22:0]                   table_index;
  modport source (output valid, output coefficient, output table_index, input ready);
  modport sink (input valid, input coefficient, input table_index, output ready);
endinterface
`default_nettype wire

>>> hdl/lsc_cfg_regs.sv
// APB register file: window lobes and phase count.
`default_nettype none
module lsc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lsc_pkg::cfg_t              cfg
);

  lsc_pkg::reg_idx_t idx;
  logic [4:0]        window_lobes;
  logic [17:0]       phase_count;

  assign idx    = lsc_pkg::reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign cfg    = '{window_lobes: window_lobes, phase_count: phase_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_lobes <= 5'd3;
      phase_count  <= 18'd44100;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        lsc_pkg::REG_WINDOW_LOBES: window_lobes <= pwdata[4:0];
        lsc_pkg::REG_PHASE_COUNT:  phase_count  <= pwdata[17:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lsc_pkg::REG_WINDOW_LOBES: prdata = 32'(window_lobes);
      lsc_pkg::REG_PHASE_COUNT:  prdata = 32'(phase_count);
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/lsc_front.sv
// Front stages: effective registers, position, magnitude and table index.
`default_nettype none
module lsc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  lsc_pkg::cfg_t   cfg,
  lsc_in_if.sink          in_ch,
  output lsc_pkg::front_t fo
);

  logic [4:0]         a_eff;
  logic [17:0]        r_eff;
  logic signed [6:0]  t;
  logic               f1_valid;
  logic signed [25:0] f1_prod;
  logic [17:0]        f1_off;
  logic [22:0]        f1_d1;
  logic [22:0]        f1_d2;
  logic [22:0]        f1_idx;
  logic signed [26:0] pos;

  assign in_ch.ready = adv;

  always_comb begin
    if (cfg.window_lobes == 5'd0) begin
      a_eff = 5'd1;
    end else if (cfg.window_lobes > 5'(lsc_pkg::MAX_WINDOW)) begin
      a_eff = 5'(lsc_pkg::MAX_WINDOW);
    end else begin
      a_eff = cfg.window_lobes;
    end
    r_eff = (cfg.phase_count == 18'd0) ? 18'd1 : cfg.phase_count;
    t = $signed({2'b00, in_ch.tap_number}) + 7'sd1 - $signed({2'b00, a_eff});
  end

  assign pos = 27'(f1_prod) - 27'($signed({1'b0, f1_off}));

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      fo.valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_ch.valid;
      fo.valid <= f1_valid;
      f1_prod  <= 26'(t) * 26'($signed({1'b0, r_eff}));
      f1_off   <= in_ch.phase_offset;
      f1_d1    <= 23'(r_eff);
      f1_d2    <= 23'(a_eff) * 23'(r_eff);
      f1_idx   <= 23'(24'(in_ch.phase_offset) * 24'({a_eff, 1'b0})
                  + 24'(in_ch.tap_number));
      fo.zero  <= (pos == 27'sd0);
      fo.pneg  <= pos[26];
      fo.apos  <= 24'(pos[26] ? -pos : pos);
      fo.idx   <= f1_idx;
      fo.d1    <= f1_d1;
      fo.d2    <= f1_d2;
    end
  end

endmodule
`default_nettype wire

>>> hdl/lsc_sinc_lane.sv
// One sinc lane: modulo, angle divide, CORDIC sine and normalizing divide.
`default_nettype none
module lsc_sinc_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [23:0] apos,
  input  logic        pneg,
  input  logic [22:0] d,
  output logic [30:0] mag,
  output logic        neg
);

  typedef struct packed {
    logic [23:0] rem;
    logic [23:0] per;
    logic [22:0] d;
    logic [23:0] apos;
    logic        pneg;
  } mod_t;

  typedef struct packed {
    logic [54:0] rem;
    logic [31:0] quo;
    logic [22:0] d;
    logic [23:0] apos;
    logic        pneg;
  } ang_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
    logic               zr;
    logic [22:0]        d;
    logic [23:0]        apos;
    logic               pneg;
  } cor_t;

  typedef struct packed {
    logic [69:0] rem;
    logic [30:0] quo;
    logic        sat;
    logic [41:0] den;
    logic        sneg;
    logic        pneg;
  } div_t;

  mod_t mod_in;
  mod_t mod_s [1:lsc_pkg::MOD_STEPS];
  ang_t ang_in;
  ang_t ang_s [1:lsc_pkg::ANG_STEPS];
  cor_t cor_in;
  cor_t cor_s [1:lsc_pkg::CORDIC_STEPS];
  div_t div_in;
  div_t div_s [1:lsc_pkg::SINC_STEPS];

  // sine select and clamp
  logic signed [33:0] sx, sy, s;
  logic [30:0]        sel_as;
  logic               sel_sneg;
  logic [22:0]        sel_d;
  logic [23:0]        sel_apos;
  logic               sel_pneg;
  // products
  logic [53:0]        mul_num;
  logic [41:0]        mul_den;
  logic               mul_sneg;
  logic               mul_pneg;
  // dividend
  logic [69:0]        add_dvd;
  logic [41:0]        add_den;
  logic               add_sneg;
  logic               add_pneg;
  logic [23:0]        q_fix;
  logic [30:0]        m_c;

  assign mod_in = '{rem: apos, per: {d, 1'b0}, d: d, apos: apos, pneg: pneg};

  for (genvar k = 0; k < lsc_pkg::MOD_STEPS; k++) begin : g_mod
    localparam int SH = lsc_pkg::MOD_STEPS - 1 - k;
    mod_t        cur;
    mod_t        step_next;
    logic [47:0] sub;
    if (k == 0) begin : g_first
      assign cur = mod_in;
    end else begin : g_rest
      assign cur = mod_s[k];
    end
    assign sub = 48'(cur.per) << SH;
    always_comb begin
      step_next = cur;
      if (48'(cur.rem) >= sub) begin
        step_next.rem = cur.rem - 24'(sub);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        mod_s[k+1] <= step_next;
      end
    end
  end

  // negative positions map to the period minus the remainder of their magnitude
  assign q_fix = (mod_s[lsc_pkg::MOD_STEPS].pneg && mod_s[lsc_pkg::MOD_STEPS].rem != 24'd0)
               ? mod_s[lsc_pkg::MOD_STEPS].per - mod_s[lsc_pkg::MOD_STEPS].rem
               : mod_s[lsc_pkg::MOD_STEPS].rem;

  always_ff @(posedge clk) begin
    if (en) begin
      ang_in.rem  <= 55'(q_fix) << 31;
      ang_in.quo  <= 32'd0;
      ang_in.d    <= mod_s[lsc_pkg::MOD_STEPS].d;
      ang_in.apos <= mod_s[lsc_pkg::MOD_STEPS].apos;
      ang_in.pneg <= mod_s[lsc_pkg::MOD_STEPS].pneg;
    end
  end

  for (genvar j = 0; j < lsc_pkg::ANG_STEPS; j++) begin : g_ang
    localparam int SH = lsc_pkg::ANG_STEPS - 1 - j;
    ang_t        cur;
    ang_t        step_next;
    logic [55:0] sub;
    if (j == 0) begin : g_first
      assign cur = ang_in;
    end else begin : g_rest
      assign cur = ang_s[j];
    end
    assign sub = 56'(cur.d) << SH;
    always_comb begin
      step_next = cur;
      if (56'(cur.rem) >= sub) begin
        step_next.rem     = cur.rem - 55'(sub);
        step_next.quo[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ang_s[j+1] <= step_next;
      end
    end
  end

  assign cor_in = '{
    x:    lsc_pkg::CORDIC_START,
    y:    33'sd0,
    z:    $signed({2'b00, ang_s[lsc_pkg::ANG_STEPS].quo[29:0]}),
    quad: ang_s[lsc_pkg::ANG_STEPS].quo[31:30],
    zr:   (ang_s[lsc_pkg::ANG_STEPS].quo[29:0] == 30'd0),
    d:    ang_s[lsc_pkg::ANG_STEPS].d,
    apos: ang_s[lsc_pkg::ANG_STEPS].apos,
    pneg: ang_s[lsc_pkg::ANG_STEPS].pneg
  };

  for (genvar i = 0; i < lsc_pkg::CORDIC_STEPS; i++) begin : g_cor
    localparam logic signed [31:0] AT = lsc_pkg::atan_turn(i);
    cor_t               cur;
    cor_t               step_next;
    logic signed [32:0] dx, dy;
    if (i == 0) begin : g_first
      assign cur = cor_in;
    end else begin : g_rest
      assign cur = cor_s[i];
    end
    assign dx = cur.y >>> i;
    assign dy = cur.x >>> i;
    always_comb begin
      step_next = cur;
      if (!cur.z[31]) begin
        step_next.x = cur.x - dx;
        step_next.y = cur.y + dy;
        step_next.z = cur.z - AT;
      end else begin
        step_next.x = cur.x + dx;
        step_next.y = cur.y - dy;
        step_next.z = cur.z + AT;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cor_s[i+1] <= step_next;
      end
    end
  end

  always_comb begin
    sx = cor_s[lsc_pkg::CORDIC_STEPS].zr ? lsc_pkg::ONE_Q30
                                         : 34'(cor_s[lsc_pkg::CORDIC_STEPS].x);
    sy = cor_s[lsc_pkg::CORDIC_STEPS].zr ? 34'sd0 : 34'(cor_s[lsc_pkg::CORDIC_STEPS].y);
    case (cor_s[lsc_pkg::CORDIC_STEPS].quad)
      2'd0:    s = sy;
      2'd1:    s = sx;
      2'd2:    s = -sy;
      default: s = -sx;
    endcase
    if (s > lsc_pkg::ONE_Q30) begin
      s = lsc_pkg::ONE_Q30;
    end
    if (s < -lsc_pkg::ONE_Q30) begin
      s = -lsc_pkg::ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_as   <= 31'(s[33] ? -s : s);
      sel_sneg <= s[33];
      sel_d    <= cor_s[lsc_pkg::CORDIC_STEPS].d;
      sel_apos <= cor_s[lsc_pkg::CORDIC_STEPS].apos;
      sel_pneg <= cor_s[lsc_pkg::CORDIC_STEPS].pneg;

      mul_num  <= 54'(sel_as) * 54'(sel_d);
      mul_den  <= 42'(sel_apos) * 42'(lsc_pkg::PI_Q16);
      mul_sneg <= sel_sneg;
      mul_pneg <= sel_pneg;

      // round to nearest: add half the divisor before dividing
      add_dvd  <= (70'(mul_num) << 16) + 70'(mul_den >> 1);
      add_den  <= mul_den;
      add_sneg <= mul_sneg;
      add_pneg <= mul_pneg;
    end
  end

  assign div_in = '{rem: add_dvd, quo: 31'd0, sat: 1'b0, den: add_den,
                    sneg: add_sneg, pneg: add_pneg};

  for (genvar j = 0; j < lsc_pkg::SINC_STEPS; j++) begin : g_div
    localparam int SH = lsc_pkg::SINC_STEPS - 1 - j;
    div_t        cur;
    div_t        step_next;
    logic [73:0] sub;
    logic        sat_now;
    if (j == 0) begin : g_first
      assign cur     = div_in;
      assign sat_now = 74'(div_in.rem) >= (74'(div_in.den) << lsc_pkg::SINC_STEPS);
    end else begin : g_rest
      assign cur     = div_s[j];
      assign sat_now = div_s[j].sat;
    end
    assign sub = 74'(cur.den) << SH;
    always_comb begin
      step_next     = cur;
      step_next.sat = sat_now;
      if (74'(cur.rem) >= sub) begin
        step_next.rem     = cur.rem - 70'(sub);
        step_next.quo[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div_s[j+1] <= step_next;
      end
    end
  end

  assign m_c = (div_s[lsc_pkg::SINC_STEPS].sat
               || div_s[lsc_pkg::SINC_STEPS].quo > lsc_pkg::ONE_MAG)
             ? lsc_pkg::ONE_MAG : div_s[lsc_pkg::SINC_STEPS].quo;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= m_c;
      neg <= (div_s[lsc_pkg::SINC_STEPS].sneg != div_s[lsc_pkg::SINC_STEPS].pneg)
             && (m_c != 31'd0);
    end
  end

endmodule
`default_nettype wire

>>> hdl/lsc_back.sv
// Product, rounding, saturation and output register with skid stage.
`default_nettype none
module lsc_back (
  input  logic           clk,
  input  logic           rst,
  input  lsc_pkg::side_t side,
  input  logic [30:0]    m1,
  input  logic           n1,
  input  logic [30:0]    m2,
  input  logic           n2,
  output logic           adv,
  lsc_out_if.source      out_ch
);

  logic                          b1_valid;
  logic                          b1_zero;
  logic [22:0]                   b1_idx;
  logic [61:0]                   b1_prod;
  logic                          b1_neg;
  logic [62:0]                   rnd;
  logic [lsc_pkg::COEF_BITS:0]   mag;
  logic [lsc_pkg::COEF_BITS-1:0] coef_c;
  logic                          out_valid;
  logic [lsc_pkg::COEF_BITS-1:0] out_coef;
  logic [22:0]                   out_idx;
  logic                          skid_v;
  logic [lsc_pkg::COEF_BITS-1:0] skid_coef;
  logic [22:0]                   skid_idx;

  assign adv = !skid_v;

  assign rnd = 63'(b1_prod) + (63'(1) << (lsc_pkg::ROUND_SH - 1));
  assign mag = rnd[lsc_pkg::ROUND_SH +: lsc_pkg::COEF_BITS + 1];

  always_comb begin
    if (b1_zero) begin
      coef_c = lsc_pkg::COEF_MAX;
    end else if (b1_neg) begin
      coef_c = (mag > ({1'b0, lsc_pkg::COEF_MAX} + 1'b1))
             ? lsc_pkg::COEF_MIN : lsc_pkg::COEF_BITS'(~mag + 1'b1);
    end else begin
      coef_c = (mag > {1'b0, lsc_pkg::COEF_MAX})
             ? lsc_pkg::COEF_MAX : lsc_pkg::COEF_BITS'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_zero <= side.zero;
      b1_idx  <= side.idx;
      b1_prod <= 62'(m1) * 62'(m2);
      b1_neg  <= n1 ^ n2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else begin
      if (adv) begin
        b1_valid <= side.valid;
      end
      if (!out_valid || out_ch.ready) begin
        if (skid_v) begin
          out_valid <= 1'b1;
          out_coef  <= skid_coef;
          out_idx   <= skid_idx;
          skid_v    <= 1'b0;
        end else begin
          out_valid <= b1_valid;
          out_coef  <= coef_c;
          out_idx   <= b1_idx;
        end
      end else if (!skid_v && b1_valid) begin
        skid_v    <= 1'b1;
        skid_coef <= coef_c;
        skid_idx  <= b1_idx;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.coefficient = out_coef;
  assign out_ch.table_index = out_idx;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (b1_valid && adv && out_valid && !out_ch.ready) |=> skid_v)
    else $error("result lost while output stalled");

  a_zero_is_max: assert property (@(posedge clk) disable iff (rst)
    (b1_valid && b1_zero && !skid_v && (!out_valid || out_ch.ready))
      |=> (out_coef == lsc_pkg::COEF_MAX))
    else $error("zero position did not give the saturated unit value");

endmodule
`default_nettype wire

>>> hdl/lanczos_sinc_coefficient_generator_top.sv
// Top level of the Lanczos windowed-sinc coefficient generator.
// Requests arrive on in_ch (phase_offset, tap_number) with valid/ready;
// each request yields one result on out_ch (Q1.15 coefficient and the
// grouped table index phase_offset*2*a + tap_number).
// window_lobes (0x0) and phase_count (0x4) must be set over the APB port
// only while no request is in flight; the block itself does not enforce it.
// Path from the accepting edge to out_ch.valid: two front stages, a
// 115-stage sinc lane per sine (23 modulo steps, 32 angle divide steps,
// 24 CORDIC steps, 31 normalizing divide steps and five glue stages,
// the two lanes side by side), one product stage and the output register.
// One request is taken every cycle while the skid register is empty.
// When out_ch stalls, the result in flight lands in a skid register and
// the whole pipeline holds; in_ch.ready drops only while the skid is full.
// Reset clears all valid bits and loads window_lobes=3, phase_count=44100.
`default_nettype none
module lanczos_sinc_coefficient_generator_top (
  input  logic                       clk,
  input  logic                       rst,
  lsc_in_if.sink                     in_ch,
  lsc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  lsc_pkg::cfg_t   cfg;
  lsc_pkg::front_t fo;
  lsc_pkg::side_t  side_line [1:lsc_pkg::LANE_LAT];
  logic            adv;
  logic [30:0]     m1, m2;
  logic            n1, n2;

  lsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .cfg   (cfg),
    .in_ch (in_ch),
    .fo    (fo)
  );

  lsc_sinc_lane u_lane_phase (
    .clk  (clk),
    .en   (adv),
    .apos (fo.apos),
    .pneg (fo.pneg),
    .d    (fo.d1),
    .mag  (m1),
    .neg  (n1)
  );

  lsc_sinc_lane u_lane_window (
    .clk  (clk),
    .en   (adv),
    .apos (fo.apos),
    .pneg (fo.pneg),
    .d    (fo.d2),
    .mag  (m2),
    .neg  (n2)
  );

  // valid, zero flag and index ride alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= lsc_pkg::LANE_LAT; k++) begin
        side_line[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side_line[1] <= '{valid: fo.valid, zero: fo.zero, idx: fo.idx};
      for (int k = 2; k <= lsc_pkg::LANE_LAT; k++) begin
        side_line[k] <= side_line[k-1];
      end
    end
  end

  lsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .side   (side_line[lsc_pkg::LANE_LAT]),
    .m1     (m1),
    .n1     (n1),
    .m2     (m2),
    .n2     (n2),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
